>>> design/adsr_pkg.sv
// Shared types and constants for the linear ADSR envelope generator.
package adsr_pkg;

    localparam int LEVEL_FRAC_BITS = 24;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int SAMPLES_W       = 20;
    localparam int STEP_W          = 25;
    localparam int NOTE_W          = 7;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        REG_ATTACK_SAMPLES  = 3'd0,
        REG_DECAY_SAMPLES   = 3'd1,
        REG_RELEASE_SAMPLES = 3'd2,
        REG_ATTACK_STEP     = 3'd3,
        REG_DECAY_STEP      = 3'd4,
        REG_RELEASE_STEP    = 3'd5,
        REG_SUSTAIN_LEVEL   = 3'd6
    } reg_idx_t;

    localparam logic [SAMPLES_W-1:0] ATTACK_SAMPLES_RST  = SAMPLES_W'(4800);
    localparam logic [SAMPLES_W-1:0] DECAY_SAMPLES_RST   = SAMPLES_W'(9600);
    localparam logic [SAMPLES_W-1:0] RELEASE_SAMPLES_RST = SAMPLES_W'(9600);
    localparam logic [STEP_W-1:0]    ATTACK_STEP_RST     = STEP_W'(3495);
    localparam logic [STEP_W-1:0]    DECAY_STEP_RST      = STEP_W'(-874);
    localparam logic [STEP_W-1:0]    RELEASE_STEP_RST    = STEP_W'(-874);
    localparam logic [LEVEL_W-1:0]   SUSTAIN_LEVEL_RST   = LEVEL_W'(8388608);

endpackage

>>> design/adsr_envelope_generator_core.sv
// Linear ADSR envelope generator core: item channels, APB register port and envelope state.
//
// The block takes one item per clock: a sample tick, a note-on or a note-off, and gives one
// result per item, the envelope level (unsigned Q1.24, clamped to zero..one) and phase after
// that item. The whole update (phase choice, level step and clamp, time counters) sits in one
// level of logic in front of the state registers, which double as the result register, so an
// item accepted at one edge has its result on m_tdata from the next cycle on. An item is taken
// whenever the result register is empty or its result is being taken in the same cycle, so the
// sustained rate is one item per clock as long as the result side keeps up. The user must
// write registers through the APB port only while no item is in flight; nothing enforces it.
module adsr_envelope_generator_core
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = 22
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Item input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [6:0] note, [7] zero
    input  logic [1:0]            s_tuser,   // [1:0] operation
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [24:0] level, [27:25] phase, [31:28] zero
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Wide enough for attack plus decay, and for release origin plus release time.
    localparam int CMP_W = ((TIME_BITS > SAMPLES_W + 1) ? TIME_BITS : SAMPLES_W + 1) + 1;
    localparam int SUM_W = LEVEL_W + 2;
    localparam logic [TIME_BITS-1:0]    TIME_MAX    = {TIME_BITS{1'b1}};
    localparam logic signed [SUM_W-1:0] LEVEL_ONE_S = SUM_W'(LEVEL_ONE);

    // Configuration registers
    logic [SAMPLES_W-1:0] attack_samples_reg;
    logic [SAMPLES_W-1:0] decay_samples_reg;
    logic [SAMPLES_W-1:0] release_samples_reg;
    logic [STEP_W-1:0]    attack_step_reg;
    logic [STEP_W-1:0]    decay_step_reg;
    logic [STEP_W-1:0]    release_step_reg;
    logic [LEVEL_W-1:0]   sustain_level_reg;

    // Envelope state
    logic [LEVEL_W-1:0]   env_level_reg,      env_level_next;
    logic [TIME_BITS-1:0] elapsed_reg,        elapsed_next;
    logic [TIME_BITS-1:0] release_origin_reg, release_origin_next;
    phase_t               env_phase_reg,      env_phase_next;
    logic                 gate_reg,           gate_next;
    logic                 releasing_reg,      releasing_next;
    logic [NOTE_W-1:0]    held_note_reg,      held_note_next;
    logic                 m_valid_reg,        m_valid_next;

    logic                 in_accept;
    op_t                  in_op;
    logic [NOTE_W-1:0]    in_note;
    logic [CMP_W-1:0]     elapsed_ext;
    logic [CMP_W-1:0]     attack_decay;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]     release_sum;
    logic [CMP_W-1:0]     release_target;
    logic signed [SUM_W-1:0] level_s;
    logic signed [SUM_W-1:0] step_s;
    logic signed [SUM_W-1:0] level_sum;
    logic [LEVEL_W-1:0]   level_stepped;
    logic [LEVEL_W-1:0]   sustain_clamped;
    phase_t               tick_phase;
    logic                 cfg_write;
    logic [2:0]           cfg_index;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_samples_reg  <= ATTACK_SAMPLES_RST;
            decay_samples_reg   <= DECAY_SAMPLES_RST;
            release_samples_reg <= RELEASE_SAMPLES_RST;
            attack_step_reg     <= ATTACK_STEP_RST;
            decay_step_reg      <= DECAY_STEP_RST;
            release_step_reg    <= RELEASE_STEP_RST;
            sustain_level_reg   <= SUSTAIN_LEVEL_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_ATTACK_SAMPLES:  attack_samples_reg  <= pwdata[SAMPLES_W-1:0];
                REG_DECAY_SAMPLES:   decay_samples_reg   <= pwdata[SAMPLES_W-1:0];
                REG_RELEASE_SAMPLES: release_samples_reg <= pwdata[SAMPLES_W-1:0];
                REG_ATTACK_STEP:     attack_step_reg     <= pwdata[STEP_W-1:0];
                REG_DECAY_STEP:      decay_step_reg      <= pwdata[STEP_W-1:0];
                REG_RELEASE_STEP:    release_step_reg    <= pwdata[STEP_W-1:0];
                REG_SUSTAIN_LEVEL:   sustain_level_reg   <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_ATTACK_SAMPLES:  prdata = CFG_DATA_W'(attack_samples_reg);
            REG_DECAY_SAMPLES:   prdata = CFG_DATA_W'(decay_samples_reg);
            REG_RELEASE_SAMPLES: prdata = CFG_DATA_W'(release_samples_reg);
            REG_ATTACK_STEP:     prdata = CFG_DATA_W'(attack_step_reg);
            REG_DECAY_STEP:      prdata = CFG_DATA_W'(decay_step_reg);
            REG_RELEASE_STEP:    prdata = CFG_DATA_W'(release_step_reg);
            REG_SUSTAIN_LEVEL:   prdata = CFG_DATA_W'(sustain_level_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s_tready  = ~m_valid_reg | m_tready;
    assign in_accept = s_tvalid & s_tready;
    assign in_op     = op_t'(s_tuser);
    assign in_note   = s_tdata[NOTE_W-1:0];

    // The state registers hold the latest result, so they feed the output directly.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, env_phase_reg, env_level_reg};

    // ------------------------------------------------------------------
    // Tick datapath
    // ------------------------------------------------------------------
    assign elapsed_ext  = CMP_W'(elapsed_reg);
    assign attack_decay = CMP_W'(attack_samples_reg) + CMP_W'(decay_samples_reg);
    assign elapsed_inc  = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign release_sum  = CMP_W'(release_origin_reg) + CMP_W'(release_samples_reg);
    assign release_target = (release_sum > CMP_W'(TIME_MAX)) ? CMP_W'(TIME_MAX) : release_sum;

    always_comb begin
        if (gate_reg && (elapsed_ext < CMP_W'(attack_samples_reg))) begin
            tick_phase = PH_ATTACK;
        end else if (gate_reg && (elapsed_ext < attack_decay)) begin
            tick_phase = PH_DECAY;
        end else if (gate_reg) begin
            tick_phase = PH_SUSTAIN;
        end else if (releasing_reg) begin
            tick_phase = PH_RELEASE;
        end else begin
            tick_phase = PH_IDLE;
        end
    end

    // Attack steps are unsigned, decay and release steps are two's complement.
    always_comb begin
        case (tick_phase)
            PH_ATTACK:  step_s = SUM_W'(attack_step_reg);
            PH_DECAY:   step_s = SUM_W'(signed'(decay_step_reg));
            default:    step_s = SUM_W'(signed'(release_step_reg));
        endcase
    end

    assign level_s   = SUM_W'(env_level_reg);
    assign level_sum = level_s + step_s;

    always_comb begin
        if (level_sum < 0) begin
            level_stepped = '0;
        end else if (level_sum > LEVEL_ONE_S) begin
            level_stepped = LEVEL_ONE;
        end else begin
            level_stepped = level_sum[LEVEL_W-1:0];
        end
    end

    assign sustain_clamped = (sustain_level_reg > LEVEL_ONE) ? LEVEL_ONE : sustain_level_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        env_level_next      = env_level_reg;
        elapsed_next        = elapsed_reg;
        release_origin_next = release_origin_reg;
        env_phase_next      = env_phase_reg;
        gate_next           = gate_reg;
        releasing_next      = releasing_reg;
        held_note_next      = held_note_reg;
        m_valid_next        = m_valid_reg & ~m_tready;

        if (in_accept) begin
            m_valid_next = 1'b1;
            case (in_op)
                OP_TICK: begin
                    env_phase_next = tick_phase;
                    case (tick_phase)
                        PH_ATTACK, PH_DECAY: begin
                            env_level_next      = level_stepped;
                            elapsed_next        = elapsed_inc;
                            release_origin_next = elapsed_inc;
                        end
                        PH_SUSTAIN: begin
                            env_level_next      = sustain_clamped;
                            elapsed_next        = elapsed_inc;
                            release_origin_next = elapsed_inc;
                        end
                        PH_RELEASE: begin
                            env_level_next = level_stepped;
                            elapsed_next   = elapsed_inc;
                            // Release ends in the tick that reaches its target.
                            if (CMP_W'(elapsed_inc) >= release_target) begin
                                releasing_next = 1'b0;
                                env_phase_next = PH_IDLE;
                            end
                        end
                        default: begin
                            env_level_next      = '0;
                            elapsed_next        = '0;
                            release_origin_next = '0;
                        end
                    endcase
                end
                OP_NOTE_ON: begin
                    gate_next           = 1'b1;
                    releasing_next      = 1'b0;
                    elapsed_next        = '0;
                    release_origin_next = '0;
                    held_note_next      = in_note;
                end
                OP_NOTE_OFF: begin
                    if (held_note_reg == in_note) begin
                        gate_next      = 1'b0;
                        releasing_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_level_reg      <= '0;
            elapsed_reg        <= '0;
            release_origin_reg <= '0;
            env_phase_reg      <= PH_IDLE;
            gate_reg           <= 1'b0;
            releasing_reg      <= 1'b0;
            held_note_reg      <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            env_level_reg      <= env_level_next;
            elapsed_reg        <= elapsed_next;
            release_origin_reg <= release_origin_next;
            env_phase_reg      <= env_phase_next;
            gate_reg           <= gate_next;
            releasing_reg      <= releasing_next;
            held_note_reg      <= held_note_next;
            m_valid_reg        <= m_valid_next;
        end
    end

endmodule

>>> tb/adsr_envelope_generator_core_tb.sv
// Self-checking testbench for the linear ADSR envelope generator core.
`timescale 1ns / 100ps

module adsr_envelope_generator_core_tb;
    import adsr_pkg::*;

    localparam int     TIME_BITS      = 22;
    localparam longint TIME_MAX       = (longint'(1) << TIME_BITS) - 1;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     SEG_ITEMS      = 80;

    typedef struct {
        op_t        op;
        logic [6:0] note;
    } env_event_t;

    typedef struct {
        logic [24:0] level;
        phase_t      phase;
    } env_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [6:0] note, [7] zero
    logic [1:0]  s_tuser  = '0;     // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [24:0] level, [27:25] phase, [31:28] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    adsr_envelope_generator_core #(.TIME_BITS(TIME_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Register copies, loaded at the same edge the block takes the write.
    logic [19:0] atk_len = ATTACK_SAMPLES_RST;
    logic [19:0] dec_len = DECAY_SAMPLES_RST;
    logic [19:0] rel_len = RELEASE_SAMPLES_RST;
    logic [24:0] atk_inc = ATTACK_STEP_RST;
    logic [24:0] dec_inc = DECAY_STEP_RST;
    logic [24:0] rel_inc = RELEASE_STEP_RST;
    logic [24:0] sus_lvl = SUSTAIN_LEVEL_RST;

    // Envelope state as the block should hold it.
    longint      env_lvl     = 0;
    longint      tick_count  = 0;
    longint      gate_origin = 0;
    phase_t      cur_phase   = PH_IDLE;
    logic        gate_on     = 1'b0;
    logic        in_release  = 1'b0;
    logic [6:0]  held_key    = '0;

    env_event_t  item_q[$];
    env_result_t level_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int settings_used = 1;
    int quiet_cycles  = 0;
    int phase_hits[5] = '{default: 0};

    function automatic env_event_t make_event(op_t op, logic [6:0] note);
        env_event_t ev;
        ev.op = op;
        ev.note = note;
        return ev;
    endfunction

    // A tick most of the time, now and then a stray event that should do nothing useful.
    function automatic env_event_t tick_or_noise();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return make_event(OP_NONE, 7'($urandom_range(127)));
        else if (pick < 6)
            return make_event(OP_NOTE_OFF, 7'($urandom_range(127)));
        return make_event(OP_TICK, 7'($urandom_range(127)));
    endfunction

    task automatic advance_envelope(input env_event_t ev, output env_result_t res);
        longint ad_end;
        longint rel_end;
        case (ev.op)
            OP_TICK: begin
                ad_end = longint'(atk_len) + longint'(dec_len);
                if (gate_on && tick_count < longint'(atk_len))
                    cur_phase = PH_ATTACK;
                else if (gate_on && tick_count < ad_end)
                    cur_phase = PH_DECAY;
                else if (gate_on)
                    cur_phase = PH_SUSTAIN;
                else if (in_release)
                    cur_phase = PH_RELEASE;
                else
                    cur_phase = PH_IDLE;

                case (cur_phase)
                    PH_ATTACK, PH_DECAY, PH_SUSTAIN: begin
                        if (cur_phase == PH_ATTACK)
                            env_lvl += longint'(atk_inc);
                        else if (cur_phase == PH_DECAY)
                            env_lvl += longint'($signed(dec_inc));
                        else
                            env_lvl = longint'(sus_lvl);
                        if (tick_count < TIME_MAX)
                            tick_count++;
                        gate_origin = tick_count;
                    end
                    PH_RELEASE: begin
                        rel_end = gate_origin + longint'(rel_len);
                        if (rel_end > TIME_MAX)
                            rel_end = TIME_MAX;
                        env_lvl += longint'($signed(rel_inc));
                        if (tick_count < TIME_MAX)
                            tick_count++;
                        if (tick_count >= rel_end) begin
                            in_release = 1'b0;
                            cur_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        env_lvl = 0;
                        tick_count = 0;
                        gate_origin = 0;
                    end
                endcase

                if (env_lvl < 0)
                    env_lvl = 0;
                if (env_lvl > longint'(LEVEL_ONE))
                    env_lvl = longint'(LEVEL_ONE);
            end
            OP_NOTE_ON: begin
                gate_on = 1'b1;
                in_release = 1'b0;
                tick_count = 0;
                gate_origin = 0;
                held_key = ev.note;
            end
            OP_NOTE_OFF: begin
                if (held_key == ev.note) begin
                    gate_on = 1'b0;
                    in_release = 1'b1;
                end
            end
            default: ;
        endcase
        res.level = 25'(env_lvl);
        res.phase = cur_phase;
    endtask

    task automatic load_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
        case (reg_idx_t'(addr >> 2))
            REG_ATTACK_SAMPLES:  atk_len = val[19:0];
            REG_DECAY_SAMPLES:   dec_len = val[19:0];
            REG_RELEASE_SAMPLES: rel_len = val[19:0];
            REG_ATTACK_STEP:     atk_inc = val[24:0];
            REG_DECAY_STEP:      dec_inc = val[24:0];
            REG_RELEASE_STEP:    rel_inc = val[24:0];
            REG_SUSTAIN_LEVEL:   sus_lvl = val[24:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= 10)
            $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Sender: presents the next pending item unless it decides to idle this cycle.
    always @(posedge aclk) begin
        env_event_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, nxt.note};
                s_tuser  <= nxt.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Checks results, predicts accepted items, tracks register writes and the watchdog.
    always @(posedge aclk) begin
        env_result_t want;
        env_result_t got;
        env_event_t  ev;
        logic        busy;
        if (aresetn) begin
            busy = 1'b0;
            if (m_tvalid && m_tready) begin
                busy = 1'b1;
                results_seen++;
                got.level = m_tdata[24:0];
                got.phase = phase_t'(m_tdata[27:25]);
                if (m_tdata[27:25] <= 3'd4)
                    phase_hits[m_tdata[27:25]]++;
                if (level_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, m_tdata);
                end else begin
                    want = level_q.pop_front();
                    if (got.level !== want.level)
                        report_mismatch("level", want.level, m_tdata[24:0]);
                    if (m_tdata[27:25] !== want.phase)
                        report_mismatch("phase", want.phase, m_tdata[27:25]);
                end
            end
            if (s_tvalid && s_tready) begin
                busy = 1'b1;
                items_taken++;
                ev = make_event(op_t'(s_tuser), s_tdata[6:0]);
                advance_envelope(ev, want);
                level_q.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                busy = 1'b1;
                load_register(paddr, pwdata);
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_settings(input int a, input int d, input int r,
                                  input logic [31:0] a_inc, input logic [31:0] d_inc,
                                  input logic [31:0] r_inc, input logic [31:0] sus);
        write_reg(REG_ATTACK_SAMPLES, a);
        write_reg(REG_DECAY_SAMPLES, d);
        write_reg(REG_RELEASE_SAMPLES, r);
        write_reg(REG_ATTACK_STEP, a_inc);
        write_reg(REG_DECAY_STEP, d_inc);
        write_reg(REG_RELEASE_STEP, r_inc);
        write_reg(REG_SUSTAIN_LEVEL, sus);
        settings_used++;
    endtask

    // Well-formed notes with random content: note-on, ticks, mostly a matching note-off,
    // then ticks through the release and beyond.
    task automatic queue_notes(input int budget, input int on_span, input int off_span);
        int         n;
        int         pick;
        logic [6:0] key;
        n = 0;
        while (n < budget) begin
            key = 7'($urandom_range(127));
            item_q.push_back(make_event(OP_NOTE_ON, key));
            n++;
            repeat ($urandom_range(on_span)) begin
                item_q.push_back(tick_or_noise());
                n++;
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                item_q.push_back(make_event(OP_NOTE_OFF, key));
                n++;
            end else if (pick < 93) begin
                item_q.push_back(make_event(OP_NOTE_OFF, 7'($urandom_range(127))));
                n++;
            end
            repeat ($urandom_range(off_span)) begin
                item_q.push_back(tick_or_noise());
                n++;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (item_q.size() != 0 || s_tvalid || level_q.size() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic random_short_segment();
        int a;
        int d;
        int r;
        a = $urandom_range(12);
        d = $urandom_range(12);
        r = $urandom_range(16);
        write_settings(a, d, r, $urandom_range(16777216), -$urandom_range(16777216),
                       -$urandom_range(16777216), $urandom_range(16777216));
        queue_notes(SEG_ITEMS, a + d + 6, r + 6);
        wait_for_drain();
    endtask

    initial begin
        send_idle_pct = 27;
        recv_idle_pct = 74;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items on the reset settings. A note-off for the stored note starts a
        // release even though no note-on came first.
        item_q.push_back(make_event(OP_NOTE_OFF, 7'd0));
        item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_TICK, 7'd127));
        item_q.push_back(make_event(OP_NONE, 7'd5));
        item_q.push_back(make_event(OP_NOTE_ON, 7'd127));
        repeat (3) item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_NOTE_OFF, 7'd126));
        item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_NOTE_OFF, 7'd127));
        repeat (2) item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_NOTE_ON, 7'd0));
        item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_NOTE_ON, 7'd85));
        item_q.push_back(make_event(OP_TICK, 7'd42));
        item_q.push_back(make_event(OP_NOTE_OFF, 7'd85));
        item_q.push_back(make_event(OP_TICK, 7'd0));
        item_q.push_back(make_event(OP_NONE, 7'd127));
        item_q.push_back(make_event(OP_TICK, 7'd0));
        wait_for_drain();

        // Short envelope whose attack overshoots one and is clamped.
        write_settings(8, 6, 10, 32'h0020_0000, -32'sh0010_0000, -32'sh0008_0000,
                       32'h0060_0000);
        queue_notes(SEG_ITEMS, 20, 16);
        wait_for_drain();

        // Zero durations and full-scale steps: straight to sustain, release ends at once.
        write_settings(0, 0, 0, 16777216, -16777216, -16777216, 16777216);
        queue_notes(SEG_ITEMS, 6, 6);
        wait_for_drain();

        send_idle_pct = 74;
        recv_idle_pct = 27;
        random_short_segment();

        // Out-of-range steps and sustain; upper data bits are don't-care.
        write_settings(3, 4, 5, 32'h01FF_FFFF, 32'h00FF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF);
        queue_notes(SEG_ITEMS, 13, 11);
        wait_for_drain();

        // Longest durations with the smallest steps.
        write_settings(1048575, 1048575, 1048575, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_notes(SEG_ITEMS, 60, 60);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_short_segment();
        random_short_segment();

        repeat (20) @(posedge aclk);
        if (level_q.size() != 0)
            report_mismatch("results still outstanding", 0, level_q.size());

        $display("Covered %0d items, %0d results, %0d register settings, %0d mismatches",
                 items_taken, results_seen, settings_used, errors);
        $display("Phases seen: idle %0d attack %0d decay %0d sustain %0d release %0d",
                 phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/adsr_pkg.sv
design/adsr_envelope_generator_core.sv
tb/adsr_envelope_generator_core_tb.sv
